// File: design/pwe_pkg.sv
// Shared constants for the prefetch window eviction block.
`timescale 1ns / 1ps
package pwe_pkg;
  localparam int KIND_BITS = 2;
  localparam int STATUS_BITS = 3;
  localparam int SPEED_BITS = 8;
  localparam int CNT_BITS = 6;
  localparam int TAIL_DIVISOR = 4;

  localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SCRUB = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_RESERVED = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_DONE = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EVICTED = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_COMPLETE = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_PRESENT = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NO_VICTIM = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_ZERO_SPEED = 3'd5;
endpackage

// File: design/pwe_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
interface pwe_req_if #(parameter int POS_BITS = 24);
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [POS_BITS-1:0] frame_pos;
  logic [POS_BITS-1:0] play_pos;
  logic signed [7:0] speed_step;
  modport source (output valid, kind, frame_pos, play_pos, speed_step, input ready);
  modport sink (input valid, kind, frame_pos, play_pos, speed_step, output ready);
endinterface

interface pwe_rsp_if #(parameter int POS_BITS = 24);
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [POS_BITS-1:0] evicted_pos;
  logic [5:0] removed_count;
  logic [5:0] occupancy;
  modport source (output valid, status, evicted_pos, removed_count, occupancy, input ready);
  modport sink (input valid, status, evicted_pos, removed_count, occupancy, output ready);
endinterface

interface pwe_cfg_if;
  logic valid;
  logic ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: design/prefetch_window_eviction_top.sv
// Top level of the prefetch window eviction block: sequencer, table and result register.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  kind, frame_pos, play_pos, speed_step
//   rsp      out  valid/ready  status, evicted_pos, removed_count, occupancy
//   cfg      in   valid/ready  data (cache_capacity; also empties the table)
//
// One request at a time. Positions live in a single-port RAM, one entry read per
// cycle during the presence and min/max scans. An insert takes a presence scan,
// and on a full table a min/max scan and, when no entry lies outside the permitted
// window, a second presence scan for the required window ends: one to three scans.
// Scrub takes one scan with a bit-serial remainder per valid entry. Reset empties
// the valid bits at once; the RAM needs no clearing. A new request is taken while
// the previous result waits in the output register; a stalled result holds the
// sequencer in its final step.
`timescale 1ns / 1ps
module prefetch_window_eviction_top
  import pwe_pkg::*;
#(
  parameter int MAX_ENTRIES = 32,
  parameter int POS_BITS = 24
) (
  input logic clk,
  input logic rst,
  pwe_req_if.sink req,
  pwe_rsp_if.source rsp,
  pwe_cfg_if.sink cfg
);
  localparam int IB = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CB = $clog2(MAX_ENTRIES + 1);
  localparam int WB = POS_BITS + 16;  // signed window arithmetic

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_MINMAX, S_DECIDE, S_REQ, S_PICK2, S_EVICT, S_INS,
    S_SCRUB, S_DIV, S_DONE
  } state_t;

  state_t state;
  logic [CNT_BITS-1:0] capacity;
  logic [MAX_ENTRIES-1:0] valid;
  logic [CB-1:0] count;
  logic [POS_BITS-1:0] fpos, ppos;
  logic [7:0] spd_abs;
  logic spd_neg;
  logic [IB:0] idx;          // scan index; extra bit marks end
  logic rd_vld;              // read data valid for previous index
  logic [IB-1:0] rd_idx;
  logic found, fnd_lo, fnd_hi;
  logic [POS_BITS-1:0] mn, mx;
  logic [IB-1:0] mn_i, mx_i;
  logic have_mm;
  logic signed [WB-1:0] lreq, hreq, lper, hper;
  logic [IB-1:0] victim;
  logic [POS_BITS-1:0] vpos;
  logic [2:0] st;
  logic [POS_BITS-1:0] ev;
  logic [CB-1:0] removed;
  logic [POS_BITS-1:0] rem;
  logic [4:0] dstep;
  logic [IB-1:0] free_i;
  logic free_ok;
  logic out_valid;
  logic out_load;

  logic ram_we;
  logic [IB-1:0] ram_addr;
  logic [POS_BITS-1:0] ram_wdata, ram_rdata;

  logic [CB-1:0] cap_eff;
  always_comb begin
    if (capacity == '0) cap_eff = CB'(1);
    else if (32'(capacity) > MAX_ENTRIES) cap_eff = CB'(MAX_ENTRIES);
    else cap_eff = CB'(capacity);
  end

  // window sizes; narrow multiplies
  logic signed [WB-1:0] tail_w, head2_w, head1_w;
  assign tail_w = WB'(32'(cap_eff) / TAIL_DIVISOR * 32'(spd_abs));
  assign head2_w = WB'((32'(cap_eff) - 1) * 32'(spd_abs));
  assign head1_w = head2_w - tail_w;

  always_comb begin
    free_ok = 1'b0;
    free_i = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_ok = 1'b1;
        free_i = IB'(i);
      end
    end
  end

  assign ram_addr = (state == S_INS) ? free_i : idx[IB-1:0];
  assign ram_we = (state == S_INS) && free_ok;
  assign ram_wdata = fpos;

  pwe_ram #(.WIDTH(POS_BITS), .DEPTH(1 << IB)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic scan_end;
  assign scan_end = (32'(idx) >= MAX_ENTRIES);
  logic signed [WB-1:0] rd_s;
  assign rd_s = WB'(ram_rdata);
  logic signed [WB-1:0] pos_gap;
  assign pos_gap = (rd_s >= WB'(ppos)) ? rd_s - WB'(ppos) : WB'(ppos) - rd_s;

  // restoring remainder, three bits a cycle
  logic [POS_BITS-1:0] div_r, div_q;
  always_comb begin
    div_r = rem;
    div_q = vpos;
    for (int k = 0; k < 3; k++) begin
      if (dstep > 5'(k + 1)) begin
        div_r = {div_r[POS_BITS-2:0], div_q[POS_BITS-1]};
        div_q = {div_q[POS_BITS-2:0], 1'b0};
        if (div_r >= POS_BITS'(spd_abs)) div_r = div_r - POS_BITS'(spd_abs);
      end
    end
  end

  // load the result register when it is empty or being drained this cycle
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= CNT_BITS'(25);
      valid <= '0;
      count <= '0;
      out_valid <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg.valid && cfg.ready) begin
            capacity <= cfg.data;
            valid <= '0;
            count <= '0;
          end else if (req.valid && req.ready) begin
            fpos <= req.frame_pos;
            ppos <= req.play_pos;
            spd_neg <= req.speed_step[7];
            spd_abs <= req.speed_step[7] ? 8'(-req.speed_step) : 8'(req.speed_step);
            ev <= '0;
            removed <= (req.kind == KIND_CLEAR) ? count : '0;
            idx <= '0;
            rd_vld <= 1'b0;
            found <= 1'b0;
            fnd_lo <= 1'b0;
            fnd_hi <= 1'b0;
            have_mm <= 1'b0;
            if (req.kind == KIND_CLEAR) begin
              st <= ST_DONE;
              valid <= '0;
              count <= '0;
              state <= S_DONE;
            end else if (req.kind == KIND_INSERT || req.kind == KIND_SCRUB) begin
              if (req.speed_step == '0) begin
                st <= ST_ZERO_SPEED;
                state <= S_DONE;
              end else begin
                st <= ST_DONE;
                state <= (req.kind == KIND_INSERT) ? S_FIND : S_SCRUB;
              end
            end else begin
              st <= ST_DONE;
              state <= S_DONE;
            end
          end
        end
        S_FIND: begin
          // presence of the new frame
          if (rd_vld && valid[rd_idx] && ram_rdata == fpos) found <= 1'b1;
          rd_idx <= idx[IB-1:0];
          rd_vld <= !scan_end;
          if (!scan_end) idx <= idx + 1'b1;
          else if (!rd_vld) begin
            if (found) begin
              st <= ST_PRESENT;
              state <= S_DONE;
            end else if (count >= cap_eff) begin
              idx <= '0;
              state <= S_MINMAX;
            end else state <= S_INS;
          end
        end
        S_MINMAX: begin
          if (rd_vld && valid[rd_idx]) begin
            have_mm <= 1'b1;
            if (!have_mm || ram_rdata < mn) begin mn <= ram_rdata; mn_i <= rd_idx; end
            if (!have_mm || ram_rdata > mx) begin mx <= ram_rdata; mx_i <= rd_idx; end
          end
          rd_idx <= idx[IB-1:0];
          rd_vld <= !scan_end;
          if (!scan_end) idx <= idx + 1'b1;
          else if (!rd_vld) begin
            if (!spd_neg) begin
              lreq <= WB'(ppos);
              hreq <= WB'(ppos) + head1_w;
              lper <= WB'(ppos) - tail_w;
              hper <= WB'(ppos) + head2_w;
            end else begin
              lreq <= WB'(ppos) - head1_w;
              hreq <= WB'(ppos);
              lper <= WB'(ppos) - head2_w;
              hper <= WB'(ppos) + tail_w;
            end
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // window bounds may be negative: compare signed
          if (!have_mm) begin
            st <= ST_NO_VICTIM;
            state <= S_DONE;
          end else if ($signed(WB'(mn)) < lper) begin
            victim <= mn_i; vpos <= mn; state <= S_EVICT;
          end else if ($signed(WB'(mx)) > hper) begin
            victim <= mx_i; vpos <= mx; state <= S_EVICT;
          end else begin
            idx <= '0;
            state <= S_REQ;
          end
        end
        S_REQ: begin
          // presence of both required window ends
          if (rd_vld && valid[rd_idx] && rd_s == lreq) fnd_lo <= 1'b1;
          if (rd_vld && valid[rd_idx] && rd_s == hreq) fnd_hi <= 1'b1;
          rd_idx <= idx[IB-1:0];
          rd_vld <= !scan_end;
          if (!scan_end) idx <= idx + 1'b1;
          else if (!rd_vld) state <= S_PICK2;
        end
        S_PICK2: begin
          if (fnd_lo && fnd_hi) begin
            st <= ST_COMPLETE; state <= S_DONE;
          end else if ($signed(WB'(mn)) < lreq) begin
            victim <= mn_i; vpos <= mn; state <= S_EVICT;
          end else if ($signed(WB'(mx)) > hreq) begin
            victim <= mx_i; vpos <= mx; state <= S_EVICT;
          end else begin
            st <= ST_NO_VICTIM; state <= S_DONE;
          end
        end
        S_EVICT: begin
          valid[victim] <= 1'b0;
          count <= count - 1'b1;
          ev <= vpos;
          removed <= CB'(1);
          st <= ST_EVICTED;
          state <= S_INS;
        end
        S_INS: begin
          if (free_ok) begin
            valid[free_i] <= 1'b1;
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_SCRUB: begin
          // read entry, then run bit-serial remainder in S_DIV
          if (rd_vld && valid[rd_idx]) begin
            rem <= '0;
            dstep <= 5'(POS_BITS + 1);
            vpos <= POS_BITS'(pos_gap);
            rd_vld <= 1'b0;
            state <= S_DIV;
          end else if (!scan_end) begin
            rd_idx <= idx[IB-1:0];
            rd_vld <= 1'b1;
            idx <= idx + 1'b1;
          end else begin
            rd_vld <= 1'b0;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (dstep == '0) begin
            if (rem != '0) begin
              valid[rd_idx] <= 1'b0;
              count <= count - 1'b1;
              removed <= removed + 1'b1;
            end
            state <= S_SCRUB;
          end else begin
            rem <= div_r;
            vpos <= div_q;
            dstep <= (dstep > 5'd3) ? dstep - 5'd3 : '0;
          end
        end
        S_DONE: begin
          // hold here until the result register is free
          if (out_load) begin
            rsp.status <= st;
            rsp.evicted_pos <= ev;
            rsp.removed_count <= 6'(removed);
            rsp.occupancy <= 6'(count);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (rst)
    32'($countones(valid)) == 32'(count)) else $error("occupancy mismatch");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg.ready |-> state == S_IDLE) else $error("config taken while busy");
  a_evict: assert property (@(posedge clk) disable iff (rst)
    state == S_EVICT |-> valid[victim]) else $error("victim not valid");
`endif
endmodule

// File: design/pwe_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module pwe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
